// ----- rtl/core/ptt_pkg.sv -----
// Shared types and constants for the periodic timer table.
// Depends on nothing; every other file of the block uses it.
package ptt_pkg;

	localparam int KEY_W       = 16;
	localparam int PERIOD_W    = 32;
	localparam int WORKER_W    = 8;
	localparam int TICK_W      = 32;
	localparam int ACC_W       = 32;
	localparam int ACTION_W    = 2;
	localparam int STATUS_W    = 3;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_TICK   = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_INSERTED = 3'd0,
		RES_REJECTED = 3'd1,
		RES_REMOVED  = 3'd2,
		RES_NOTFOUND = 3'd3,
		RES_EXPIRED  = 3'd4
	} res_status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_TICK
	} fsm_state_t;

	typedef enum logic [1:0] {
		TBL_NONE,
		TBL_INSERT,
		TBL_REMOVE,
		TBL_ROTATE
	} tbl_op_t;

	typedef struct packed {
		tbl_op_t               op;
		logic [KEY_W-1:0]      key;
		logic [PERIOD_W-1:0]   period;
		logic [WORKER_W-1:0]   worker;
		logic [ACC_W-1:0]      head_acc;
	} tbl_cmd_t;

	typedef struct packed {
		logic                  exists;
		logic                  full;
		logic                  head_valid;
		logic [KEY_W-1:0]      head_key;
		logic [PERIOD_W-1:0]   head_period;
		logic [WORKER_W-1:0]   head_worker;
		logic [ACC_W-1:0]      head_acc;
	} tbl_stat_t;

endpackage

// ----- rtl/core/ptt_if.sv -----
// Valid/ready channel interfaces for the periodic timer table.
// Depends on ptt_pkg for the field widths.
interface ptt_in_if;
	logic                          valid;
	logic                          ready;
	logic [ptt_pkg::ACTION_W-1:0]  action;
	logic [ptt_pkg::KEY_W-1:0]     entry_key;
	logic [ptt_pkg::PERIOD_W-1:0]  period;
	logic [ptt_pkg::WORKER_W-1:0]  work_index;
	logic [ptt_pkg::TICK_W-1:0]    now_tick;

	modport source (output valid, action, entry_key, period, work_index, now_tick,
		input ready);
	modport sink (input valid, action, entry_key, period, work_index, now_tick,
		output ready);
endinterface

interface ptt_out_if;
	logic                          valid;
	logic                          ready;
	logic [ptt_pkg::STATUS_W-1:0]  status;
	logic [ptt_pkg::KEY_W-1:0]     key_out;
	logic [ptt_pkg::WORKER_W-1:0]  worker_out;
	logic                          last;

	modport source (output valid, status, key_out, worker_out, last, input ready);
	modport sink (input valid, status, key_out, worker_out, last, output ready);
endinterface

// ----- rtl/core/ptt_table.sv -----
// Sorted, packed timer table held as a ring of registers.
// Depends on ptt_pkg for the command and status structs.
module ptt_table #(
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ptt_pkg::tbl_cmd_t  cmd,
	output ptt_pkg::tbl_stat_t stat
);
	import ptt_pkg::*;

	logic [SLOTS-1:0]    valid_q;
	logic [KEY_W-1:0]    key_q    [SLOTS];
	logic [PERIOD_W-1:0] period_q [SLOTS];
	logic [WORKER_W-1:0] worker_q [SLOTS];
	logic [ACC_W-1:0]    acc_q    [SLOTS];

	logic [SLOTS-1:0]    lt, eq, place, up_valid, dn_valid, nxt_valid;
	logic [KEY_W-1:0]    up_key [SLOTS], dn_key [SLOTS], nxt_key [SLOTS];
	logic [PERIOD_W-1:0] up_period [SLOTS], dn_period [SLOTS], nxt_period [SLOTS];
	logic [WORKER_W-1:0] up_worker [SLOTS], dn_worker [SLOTS], nxt_worker [SLOTS];
	logic [ACC_W-1:0]    up_acc [SLOTS], dn_acc [SLOTS], nxt_acc [SLOTS];
	logic                found, ins_ok;

	// Valid entries sit at the low end in ascending key order, so the
	// less-than flags form a thermometer and every move is to a neighbor.
	for (genvar g = 0; g < SLOTS; g++) begin : g_slot
		assign lt[g] = valid_q[g] && (key_q[g] < cmd.key);
		assign eq[g] = valid_q[g] && (key_q[g] == cmd.key);

		if (g == SLOTS - 1) begin : g_tail
			assign up_valid[g]  = (cmd.op == TBL_ROTATE) ? valid_q[0] : 1'b0;
			assign up_key[g]    = key_q[0];
			assign up_period[g] = period_q[0];
			assign up_worker[g] = worker_q[0];
			assign up_acc[g]    = cmd.head_acc;
		end else begin : g_mid
			assign up_valid[g]  = valid_q[g+1];
			assign up_key[g]    = key_q[g+1];
			assign up_period[g] = period_q[g+1];
			assign up_worker[g] = worker_q[g+1];
			assign up_acc[g]    = acc_q[g+1];
		end

		if (g == 0) begin : g_first
			assign place[g]     = 1'b1;
			assign dn_valid[g]  = valid_q[g];
			assign dn_key[g]    = key_q[g];
			assign dn_period[g] = period_q[g];
			assign dn_worker[g] = worker_q[g];
			assign dn_acc[g]    = acc_q[g];
		end else begin : g_rest
			assign place[g]     = lt[g-1];
			assign dn_valid[g]  = valid_q[g-1];
			assign dn_key[g]    = key_q[g-1];
			assign dn_period[g] = period_q[g-1];
			assign dn_worker[g] = worker_q[g-1];
			assign dn_acc[g]    = acc_q[g-1];
		end
	end

	assign found  = |eq;
	assign ins_ok = !found && !valid_q[SLOTS-1];

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			nxt_valid[i]  = valid_q[i];
			nxt_key[i]    = key_q[i];
			nxt_period[i] = period_q[i];
			nxt_worker[i] = worker_q[i];
			nxt_acc[i]    = acc_q[i];
			unique case (cmd.op)
				TBL_INSERT: begin
					if (ins_ok && !lt[i]) begin
						if (place[i]) begin
							nxt_valid[i]  = 1'b1;
							nxt_key[i]    = cmd.key;
							nxt_period[i] = cmd.period;
							nxt_worker[i] = cmd.worker;
							nxt_acc[i]    = '0;
						end else begin
							nxt_valid[i]  = dn_valid[i];
							nxt_key[i]    = dn_key[i];
							nxt_period[i] = dn_period[i];
							nxt_worker[i] = dn_worker[i];
							nxt_acc[i]    = dn_acc[i];
						end
					end
				end
				TBL_REMOVE: begin
					if (found && valid_q[i] && !lt[i]) begin
						nxt_valid[i]  = up_valid[i];
						nxt_key[i]    = up_key[i];
						nxt_period[i] = up_period[i];
						nxt_worker[i] = up_worker[i];
						nxt_acc[i]    = up_acc[i];
					end
				end
				TBL_ROTATE: begin
					nxt_valid[i]  = up_valid[i];
					nxt_key[i]    = up_key[i];
					nxt_period[i] = up_period[i];
					nxt_worker[i] = up_worker[i];
					nxt_acc[i]    = up_acc[i];
				end
				TBL_NONE: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= nxt_key;
		period_q <= nxt_period;
		worker_q <= nxt_worker;
		acc_q    <= nxt_acc;
	end

	assign stat.exists      = found;
	assign stat.full        = valid_q[SLOTS-1];
	assign stat.head_valid  = valid_q[0];
	assign stat.head_key    = key_q[0];
	assign stat.head_period = period_q[0];
	assign stat.head_worker = worker_q[0];
	assign stat.head_acc    = acc_q[0];

endmodule

// ----- rtl/core/periodic_timer_table_top.sv -----
// Top level of the periodic timer table: sequencer, shared add-compare unit
// and result path. Depends on ptt_pkg, ptt_if and ptt_table.
//
// Channel | Dir | Beat contents
// --------+-----+---------------------------------------------------------
// cmd     | in  | action, entry_key, period, work_index, now_tick
// res     | out | status, key_out, worker_out, last
//
// An insert or remove beat updates the table registers as it is taken; its
// single result beat goes to the held register and then to the output
// register, and no new command is taken while the held register is full.
// A tick beat walks the whole ring, one slot per step, after it is taken;
// a step waits while an expiry is found and the held expiry cannot move
// into a full output register. Each step uses the one shared adder.
// After reset the table is empty and the previous tick count is zero.
// Back-pressure on res only stalls the walk when a new expiry is found
// while the held expiry still cannot move into the output register.
module periodic_timer_table_top #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ptt_in_if.sink      cmd,
	ptt_out_if.source   res
);
	import ptt_pkg::*;

	localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	fsm_state_t           state_q, state_d;
	logic [STEP_W-1:0]    step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TICK_W-1:0]    prev_tick_q;
	logic [TICK_W-1:0]    elapsed_q;

	// Held result: the latest expiry of a walk is kept here until we know
	// whether another one follows, which decides its last flag.
	logic                 pv_q;
	res_status_t          pstat_q;
	logic [KEY_W-1:0]     pkey_q;
	logic [WORKER_W-1:0]  pwork_q;
	logic                 plast_q;

	// Output register, drives res directly.
	logic                 ov_q;
	res_status_t          ostat_q;
	logic [KEY_W-1:0]     okey_q;
	logic [WORKER_W-1:0]  owork_q;
	logic                 olast_q;

	tbl_cmd_t             tcmd;
	tbl_stat_t            tstat;

	logic                 cmd_ready, accept, out_free, last_step;
	logic [ACC_W:0]       sum;
	logic                 expire, emit, stall, step_go, push, load;
	action_t              act;
	res_status_t          load_stat;
	logic [KEY_W-1:0]     load_key;
	logic [WORKER_W-1:0]  load_work;
	logic                 load_last;

	ptt_table #(.SLOTS(SLOTS)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tcmd),
		.stat   (tstat)
	);

	assign act       = action_t'(cmd.action);
	assign cmd_ready = (state_q == FSM_IDLE) && !pv_q;
	assign accept    = cmd.valid && cmd_ready;
	assign out_free  = !ov_q || res.ready;
	assign last_step = (step_q == STEP_W'(SLOTS - 1));

	// The shared unit: one 33-bit add and one compare on the ring head.
	// Stored accumulators stay below their period, so the sum never wraps.
	assign sum    = {1'b0, tstat.head_acc} + {1'b0, elapsed_q};
	assign expire = tstat.head_valid && (sum >= {1'b0, tstat.head_period});
	assign emit   = (state_q == FSM_TICK) && expire && (cnt_q < CNT_W'(MAX_RESULTS));
	assign stall  = emit && pv_q && !out_free;
	assign step_go = (state_q == FSM_TICK) && !stall;

	// The held beat moves on at the end of a command, or when a newer
	// expiry needs its place during a walk.
	assign push = pv_q && out_free && ((state_q == FSM_IDLE) || (emit && step_go));

	always_comb begin
		tcmd.op       = TBL_NONE;
		tcmd.key      = cmd.entry_key;
		tcmd.period   = cmd.period;
		tcmd.worker   = cmd.work_index;
		tcmd.head_acc = expire ? '0 : sum[ACC_W-1:0];
		if (accept) begin
			unique case (act)
				ACT_INSERT: tcmd.op = TBL_INSERT;
				ACT_REMOVE: tcmd.op = TBL_REMOVE;
				default:    tcmd.op = TBL_NONE;
			endcase
		end else if (step_go) begin
			tcmd.op = TBL_ROTATE;
		end
	end

	always_comb begin
		load      = 1'b0;
		load_stat = RES_EXPIRED;
		load_key  = tstat.head_key;
		load_work = tstat.head_worker;
		load_last = last_step;
		if (accept) begin
			load_key  = cmd.entry_key;
			load_work = cmd.work_index;
			load_last = 1'b1;
			unique case (act)
				ACT_INSERT: begin
					load      = 1'b1;
					load_stat = (tstat.exists || tstat.full) ? RES_REJECTED : RES_INSERTED;
				end
				ACT_REMOVE: begin
					load      = 1'b1;
					load_stat = tstat.exists ? RES_REMOVED : RES_NOTFOUND;
				end
				default: begin
				end
			endcase
		end else if (step_go && emit) begin
			load = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept && act == ACT_TICK) begin
					state_d = FSM_TICK;
				end
			end
			FSM_TICK: begin
				if (step_go && last_step) begin
					state_d = FSM_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			cnt_q       <= '0;
			prev_tick_q <= '0;
			pv_q        <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			if (accept && act == ACT_TICK) begin
				step_q      <= '0;
				cnt_q       <= '0;
				prev_tick_q <= cmd.now_tick;
			end else if (step_go) begin
				step_q <= step_q + STEP_W'(1);
				if (emit) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end

			if (load) begin
				pv_q <= 1'b1;
			end else if (push) begin
				pv_q <= 1'b0;
			end

			if (push) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && act == ACT_TICK) begin
			elapsed_q <= cmd.now_tick - prev_tick_q;
		end
		if (load) begin
			pstat_q <= load_stat;
			pkey_q  <= load_key;
			pwork_q <= load_work;
			plast_q <= load_last;
		end else if (step_go && last_step) begin
			plast_q <= 1'b1;
		end
		if (push) begin
			ostat_q <= pstat_q;
			okey_q  <= pkey_q;
			owork_q <= pwork_q;
			olast_q <= plast_q;
		end
	end

	assign cmd.ready      = cmd_ready;
	assign res.valid      = ov_q;
	assign res.status     = ostat_q;
	assign res.key_out    = okey_q;
	assign res.worker_out = owork_q;
	assign res.last       = olast_q;

	// A tick beat always starts the walk at the ring head.
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_TICK |=> state_q == FSM_TICK && step_q == '0 && cnt_q == '0)
		else $error("tick walk did not start at step zero");

	// Outside a walk, a held result is always the final beat of its command.
	a_idle_final: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_IDLE && pv_q |-> plast_q)
		else $error("held result in idle is not marked last");

	// A stalled walk neither rotates the ring nor advances the step.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(step_q) && state_q == FSM_TICK)
		else $error("walk advanced during an output stall");

	// Never more expiries counted than can be reported.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("expiry count exceeded its bound");

endmodule
